[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the contact resolve block.
// Each macro samples on the rising edge of clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define PCVR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define PCVR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/pcvr_pkg.sv]
// Shared types and constants of the particle contact velocity resolve block.
// No dependencies.
package pcvr_pkg;

  localparam int MASS_W    = 16;          // inverse mass, unsigned
  localparam int TOTAL_W   = MASS_W + 1;  // sum of two inverse masses
  localparam int REST_W    = 9;           // restitution, unsigned Q1.8
  localparam int STEP_W    = 16;          // step time, unsigned Q0.16
  localparam int REST_FRAC = 8;
  localparam int STEP_FRAC = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [REST_W-1:0] REST_RESET = 9'd256;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd1092;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESTITUTION = 8'd0,
    CFG_STEP_TIME   = 8'd1
  } cfg_reg_e;

  // Pipeline control handed to the divider.
  typedef struct packed {
    logic valid;
    logic en;
  } pipe_ctrl_t;

endpackage

[rtl/particle_contact_velocity_resolve_unit.sv]
// Top level of the particle contact velocity resolve block.
// Depends on pcvr_pkg and pcvr_div.
//
// Usage:
//   s_axis carries one contact per request: tdata holds vel_a, vel_b, acc_a,
//   acc_b, contact_normal, inv_mass_a, inv_mass_b; tuser holds has_b.
//   m_axis returns one result per contact: tdata holds new_vel_a, new_vel_b;
//   tuser holds applied. Results leave in the order contacts came in.
//   The cfg channel writes restitution (index 0) or step_time (index 1);
//   other indexes are ignored. cfg_ready_o is always high. Write config
//   only while the pipeline is empty.
//   Throughput: one contact per cycle while m_axis is not stalled. The
//   bit-serial impulse divider resolves one quotient bit per stage over
//   COMPONENT_WIDTH + FRAC_BITS + 9 stages; before it lie the stages of dot
//   products and restitution, after it those of the velocity update.
//   Reset clears every valid bit and loads restitution 256 and step_time 1092.
//   When m_axis_tready is low with a result waiting, the whole pipeline
//   holds and s_axis_tready drops; nothing is dropped or repeated. Bubbles
//   move on only while m_axis_tready is high or no result waits at the output.
module particle_contact_velocity_resolve_unit #(
  parameter int COMPONENT_WIDTH = 17,
  parameter int FRAC_BITS       = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // vel_a, vel_b, acc_a, acc_b, contact_normal, inv_mass_a, inv_mass_b, zero pad
  input  logic [((5*3*COMPONENT_WIDTH+2*pcvr_pkg::MASS_W+7)/8)*8-1:0] s_axis_tdata,
  // has_b
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // new_vel_a, new_vel_b, zero pad
  output logic [((2*3*COMPONENT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // applied
  output logic                                 m_axis_tuser,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pcvr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pcvr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int CW   = COMPONENT_WIDTH;
  localparam int FW   = 3 * CW;
  localparam int MW   = pcvr_pkg::MASS_W;
  localparam int TW   = pcvr_pkg::TOTAL_W;
  localparam int RSW  = pcvr_pkg::REST_W;
  localparam int STW  = pcvr_pkg::STEP_W;
  localparam int OUTW = ((2*FW+7)/8)*8;
  localparam int DFW  = CW + 1;
  localparam int MPW  = DFW + CW;
  localparam int DTW  = MPW + 2;
  localparam int RW   = DTW - FRAC_BITS + 1;
  localparam int APW  = RW + STW + 1;
  localparam int AW   = APW - pcvr_pkg::STEP_FRAC + 1;
  localparam int SRW  = RW + RSW + 1;
  localparam int RAW  = AW + RSW + 1;
  localparam int WW   = RAW + 2;
  localparam int DLW  = WW + 2;
  localparam int LOW  = DLW / 2;
  localparam int HIW  = DLW - LOW;
  localparam int PRW  = DLW + MW;
  localparam int SL   = CW + FRAC_BITS + 9;
  localparam int SHW  = SL + 2;
  localparam int SLO  = SHW / 2;
  localparam int SHI  = SHW - SLO;
  localparam int NPW  = CW + SHW;
  localparam int RS   = FRAC_BITS + pcvr_pkg::REST_FRAC;
  localparam int DAW  = NPW - RS + 1;
  localparam int SUMW = DAW + 1;
  localparam int PRE  = 12;
  localparam int POST = 4;

  localparam int PY_VA = 0;
  localparam int PY_VB = FW;
  localparam int PY_N  = 2 * FW;
  localparam int PY_MA = 3 * FW;
  localparam int PY_MB = 3 * FW + MW;
  localparam int PY_HB = 3 * FW + 2 * MW;
  localparam int PYW   = PY_HB + 1;

  localparam int SB_VA   = 0;
  localparam int SB_VB   = FW;
  localparam int SB_N    = 2 * FW;
  localparam int SB_HB   = 3 * FW;
  localparam int SB_SKIP = 3 * FW + 1;
  localparam int SB_NEG  = 3 * FW + 2;
  localparam int SB_SAT  = 3 * FW + 3;
  localparam int SBW     = 3 * FW + 5;

  localparam logic signed [DTW:0]    VHALF = (DTW+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [APW:0]    AHALF = (APW+1)'(1) << (pcvr_pkg::STEP_FRAC - 1);
  localparam logic signed [NPW:0]    NHALF = (NPW+1)'(1) << (RS - 1);
  localparam logic signed [SUMW-1:0] CMAX  = (SUMW'(1) << (CW - 1)) - SUMW'(1);
  localparam logic signed [SUMW-1:0] CMIN  = -(SUMW'(1) << (CW - 1));

  // ---------------- config and flow control ----------------
  logic [RSW-1:0] rest_q;
  logic [STW-1:0] step_q;
  logic           en, accept;
  logic           out_vld_q;

  assign cfg_ready_o   = 1'b1;
  assign en            = m_axis_tready || !out_vld_q;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= pcvr_pkg::REST_RESET;
      step_q <= pcvr_pkg::STEP_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pcvr_pkg::CFG_RESTITUTION: rest_q <= cfg_data_i[RSW-1:0];
        pcvr_pkg::CFG_STEP_TIME:   step_q <= cfg_data_i[STW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- front stages ----------------
  logic [PRE:1]          pre_vld_q;
  logic [PYW-1:0]        pay_q  [1:PRE];
  logic [PYW-1:0]        pay_d;
  logic signed [DFW-1:0] dv_q [3], dv_d [3], dac_q [3], dac_d [3];
  logic signed [MPW-1:0] pv_q [3], pa_q [3];
  logic signed [DTW-1:0] vdot_q, adot_q;
  logic signed [RW-1:0]  adr_q;
  logic signed [RW-1:0]  sep_q  [4:8];
  logic [TW-1:0]         tot_q  [4:PRE];
  logic                  skip_q [5:PRE];
  logic signed [APW-1:0] accp_q;
  logic signed [SRW-1:0] sr_q, want0_q;
  logic signed [AW-1:0]  accv_q;
  logic signed [RAW-1:0] ra_q;
  logic                  accneg_q;
  logic signed [WW-1:0]  want_q, want_d;
  logic signed [DLW-1:0] delta_q;
  logic [DLW-1:0]        mag_q;
  logic                  neg_q  [10:PRE];
  logic [LOW+MW-1:0]     pl_q [2];
  logic [HIW+MW-1:0]     ph_q [2];
  logic [PRW-1:0]        prod_q [2];
  logic signed [DTW:0]   vr, ar;
  logic signed [APW:0]   acr;
  logic signed [WW-1:0]  wsum;

  always_comb begin
    logic               hb;
    logic signed [CW-1:0] va, vb, aa, ab;
    hb = s_axis_tuser;
    for (int i = 0; i < 3; i++) begin
      va = $signed(s_axis_tdata[0*FW + i*CW +: CW]);
      vb = $signed(s_axis_tdata[1*FW + i*CW +: CW]);
      aa = $signed(s_axis_tdata[2*FW + i*CW +: CW]);
      ab = $signed(s_axis_tdata[3*FW + i*CW +: CW]);
      dv_d[i]  = hb ? (DFW'(va) - DFW'(vb)) : DFW'(va);
      dac_d[i] = hb ? (DFW'(aa) - DFW'(ab)) : DFW'(aa);
    end
    pay_d[PY_VA +: FW] = s_axis_tdata[0*FW +: FW];
    pay_d[PY_VB +: FW] = s_axis_tdata[1*FW +: FW];
    pay_d[PY_N  +: FW] = s_axis_tdata[4*FW +: FW];
    pay_d[PY_MA +: MW] = s_axis_tdata[5*FW +: MW];
    pay_d[PY_MB +: MW] = hb ? s_axis_tdata[5*FW+MW +: MW] : '0;
    pay_d[PY_HB]       = hb;
  end

  assign vr   = (DTW+1)'(vdot_q) + VHALF;
  assign ar   = (DTW+1)'(adot_q) + VHALF;
  assign acr  = (APW+1)'(accp_q) + AHALF;
  assign wsum = WW'(want0_q) + WW'(ra_q);
  // closing velocity from acceleration lowers the target, never below zero
  assign want_d = accneg_q ? (wsum[WW-1] ? '0 : wsum) : WW'(want0_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= '0;
    end else if (en) begin
      pre_vld_q <= {pre_vld_q[PRE-1:1], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pay_q[1] <= pay_d;
      for (int k = 2; k <= PRE; k++) pay_q[k] <= pay_q[k-1];
      // stage 1..3: relative vectors, products, dot sums
      for (int i = 0; i < 3; i++) begin
        dv_q[i]  <= dv_d[i];
        dac_q[i] <= dac_d[i];
        pv_q[i]  <= dv_q[i]  * MPW'($signed(pay_q[1][PY_N + i*CW +: CW]));
        pa_q[i]  <= dac_q[i] * MPW'($signed(pay_q[1][PY_N + i*CW +: CW]));
      end
      vdot_q <= DTW'(pv_q[0]) + DTW'(pv_q[1]) + DTW'(pv_q[2]);
      adot_q <= DTW'(pa_q[0]) + DTW'(pa_q[1]) + DTW'(pa_q[2]);
      // stage 4: rounding, total inverse mass
      sep_q[4] <= RW'(vr >>> FRAC_BITS);
      adr_q    <= RW'(ar >>> FRAC_BITS);
      tot_q[4] <= TW'(pay_q[3][PY_MA +: MW]) + TW'(pay_q[3][PY_MB +: MW]);
      for (int k = 5; k <= PRE; k++) tot_q[k] <= tot_q[k-1];
      for (int k = 5; k <= 8; k++) sep_q[k] <= sep_q[k-1];
      // stage 5: product with step time
      accp_q    <= APW'(adr_q) * APW'($signed({1'b0, step_q}));
      skip_q[5] <= (sep_q[4] > 0) || (tot_q[4] == '0);
      for (int k = 6; k <= PRE; k++) skip_q[k] <= skip_q[k-1];
      // stage 6..9: restitution, target separating velocity and change
      sr_q     <= SRW'(sep_q[5]) * SRW'($signed({1'b0, rest_q}));
      accv_q   <= AW'(acr >>> pcvr_pkg::STEP_FRAC);
      ra_q     <= RAW'(accv_q) * RAW'($signed({1'b0, rest_q}));
      want0_q  <= -sr_q;
      accneg_q <= accv_q[AW-1];
      want_q   <= want_d;
      delta_q  <= DLW'(want_q) - (DLW'(sep_q[8]) <<< pcvr_pkg::REST_FRAC);
      // stage 10..12: magnitude times inverse mass, split in two partials
      neg_q[10] <= delta_q[DLW-1];
      mag_q     <= delta_q[DLW-1] ? DLW'(-delta_q) : DLW'(delta_q);
      for (int k = 11; k <= PRE; k++) neg_q[k] <= neg_q[k-1];
      pl_q[0] <= (LOW+MW)'(mag_q[LOW-1:0])   * (LOW+MW)'(pay_q[10][PY_MA +: MW]);
      ph_q[0] <= (HIW+MW)'(mag_q[DLW-1:LOW]) * (HIW+MW)'(pay_q[10][PY_MA +: MW]);
      pl_q[1] <= (LOW+MW)'(mag_q[LOW-1:0])   * (LOW+MW)'(pay_q[10][PY_MB +: MW]);
      ph_q[1] <= (HIW+MW)'(mag_q[DLW-1:LOW]) * (HIW+MW)'(pay_q[10][PY_MB +: MW]);
      for (int l = 0; l < 2; l++) begin
        prod_q[l] <= (PRW'(ph_q[l]) << LOW) + PRW'(pl_q[l]);
      end
    end
  end

  // ---------------- divider ----------------
  pcvr_pkg::pipe_ctrl_t      div_ctrl;
  logic [1:0][TW-1:0]        div_rem;
  logic [1:0][SL-1:0]        div_low;
  logic [1:0]                sat;
  logic [SBW-1:0]            div_sb;
  logic                      div_vld;
  logic [1:0][SL-1:0]        div_quot;
  logic [SBW-1:0]            div_sb_o;

  // share saturates once the quotient reaches the limit: prod >= total << SL
  for (genvar l = 0; l < 2; l++) begin : g_sat
    assign sat[l]     = (prod_q[l] >> SL) >= PRW'(tot_q[PRE]);
    assign div_rem[l] = TW'(prod_q[l] >> SL);
    assign div_low[l] = prod_q[l][SL-1:0];
  end

  assign div_ctrl.valid = pre_vld_q[PRE];
  assign div_ctrl.en    = en;
  assign div_sb = {sat, neg_q[PRE], skip_q[PRE], pay_q[PRE][PY_HB],
                   pay_q[PRE][PY_N +: FW], pay_q[PRE][PY_VB +: FW], pay_q[PRE][PY_VA +: FW]};

  pcvr_div #(
    .QW  (SL),
    .SBW (SBW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .den_i   (tot_q[PRE]),
    .rem_i   (div_rem),
    .low_i   (div_low),
    .sb_i    (div_sb),
    .valid_o (div_vld),
    .quot_o  (div_quot),
    .sb_o    (div_sb_o)
  );

  // ---------------- back stages ----------------
  logic [POST:1]              post_vld_q;
  logic [SBW-1:0]             psb_q [1:POST];
  logic signed [SHW-1:0]      sh_q [2];
  logic signed [CW+SLO:0]     nl_q [2][3];
  logic signed [CW+SHI-1:0]   nh_q [2][3];
  logic signed [NPW-1:0]      np_q [2][3];
  logic signed [DAW-1:0]      da_q [2][3];
  logic [2*FW-1:0]            out_data_q, out_data_d;
  logic                       out_user_q;

  always_comb begin
    logic signed [SUMW-1:0] s;
    logic signed [CW-1:0]   v;
    logic [FW-1:0]          na, nb;
    for (int i = 0; i < 3; i++) begin
      v = $signed(psb_q[POST][SB_VA + i*CW +: CW]);
      s = SUMW'(v) + SUMW'(da_q[0][i]);
      na[i*CW +: CW] = (s > CMAX) ? CMAX[CW-1:0] : ((s < CMIN) ? CMIN[CW-1:0] : s[CW-1:0]);
      v = $signed(psb_q[POST][SB_VB + i*CW +: CW]);
      s = SUMW'(v) - SUMW'(da_q[1][i]);
      nb[i*CW +: CW] = (s > CMAX) ? CMAX[CW-1:0] : ((s < CMIN) ? CMIN[CW-1:0] : s[CW-1:0]);
    end
    if (psb_q[POST][SB_SKIP]) begin
      out_data_d = psb_q[POST][SB_VA +: 2*FW];
    end else begin
      out_data_d[0 +: FW]  = na;
      out_data_d[FW +: FW] = psb_q[POST][SB_HB] ? nb : psb_q[POST][SB_VB +: FW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_vld_q <= '0;
      out_vld_q  <= 1'b0;
    end else if (en) begin
      post_vld_q <= {post_vld_q[POST-1:1], div_vld};
      out_vld_q  <= post_vld_q[POST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      psb_q[1] <= div_sb_o;
      for (int k = 2; k <= POST; k++) psb_q[k] <= psb_q[k-1];
      for (int l = 0; l < 2; l++) begin
        // signed share, clamped at the limit
        if (div_sb_o[SB_NEG]) begin
          sh_q[l] <= div_sb_o[SB_SAT + l] ? -(SHW'(1) << SL) : -$signed(SHW'(div_quot[l]));
        end else begin
          sh_q[l] <= div_sb_o[SB_SAT + l] ? (SHW'(1) << SL) : $signed(SHW'(div_quot[l]));
        end
        for (int i = 0; i < 3; i++) begin
          nl_q[l][i] <= (CW+SLO+1)'($signed(psb_q[1][SB_N + i*CW +: CW]))
                        * (CW+SLO+1)'($signed({1'b0, sh_q[l][SLO-1:0]}));
          nh_q[l][i] <= (CW+SHI)'($signed(psb_q[1][SB_N + i*CW +: CW]))
                        * (CW+SHI)'($signed(sh_q[l][SHW-1:SLO]));
          np_q[l][i] <= (NPW'(nh_q[l][i]) <<< SLO) + NPW'(nl_q[l][i]);
          da_q[l][i] <= DAW'(((NPW+1)'(np_q[l][i]) + NHALF) >>> RS);
        end
      end
      out_data_q <= out_data_d;
      out_user_q <= !psb_q[POST][SB_SKIP];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUTW'(out_data_q);
  assign m_axis_tuser  = out_user_q;

endmodule

[rtl/pcvr_div.sv]
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit a stage.
// Depends on pcvr_pkg. The caller guarantees the starting remainder is below the divisor.
module pcvr_div #(
  parameter int QW  = 34,
  parameter int SBW = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pcvr_pkg::pipe_ctrl_t                  ctrl_i,
  input  logic [pcvr_pkg::TOTAL_W-1:0]          den_i,
  input  logic [1:0][pcvr_pkg::TOTAL_W-1:0]     rem_i,
  input  logic [1:0][QW-1:0]                    low_i,
  input  logic [SBW-1:0]                        sb_i,
  output logic                                  valid_o,
  output logic [1:0][QW-1:0]                    quot_o,
  output logic [SBW-1:0]                        sb_o
);

  localparam int TW = pcvr_pkg::TOTAL_W;

  logic [QW:0]           vld_q;
  logic [TW-1:0]         den_q [QW];
  logic [1:0][TW-1:0]    rem_q [QW];
  logic [1:0][TW-1:0]    rem_d [QW];
  logic [1:0][QW-1:0]    wrk_q [QW+1];
  logic [1:0][QW-1:0]    wrk_d [QW];
  logic [SBW-1:0]        sb_q  [QW+1];

  // wrk holds the dividend bits still to come on top and quotient bits below
  for (genvar k = 0; k < QW; k++) begin : g_stage
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [TW:0] trial;
      logic        ge;
      assign trial = {rem_q[k][l], wrk_q[k][l][QW-1]};
      assign ge    = trial >= {1'b0, den_q[k]};
      assign rem_d[k][l] = ge ? TW'(trial - {1'b0, den_q[k]}) : trial[TW-1:0];
      assign wrk_d[k][l] = {wrk_q[k][l][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctrl_i.en) begin
      vld_q <= {vld_q[QW-1:0], ctrl_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      den_q[0] <= den_i;
      rem_q[0] <= rem_i;
      wrk_q[0] <= low_i;
      sb_q[0]  <= sb_i;
      for (int k = 1; k < QW; k++) begin
        den_q[k] <= den_q[k-1];
        rem_q[k] <= rem_d[k-1];
      end
      for (int k = 1; k <= QW; k++) begin
        wrk_q[k] <= wrk_d[k-1];
        sb_q[k]  <= sb_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quot_o  = wrk_q[QW];
  assign sb_o    = sb_q[QW];

endmodule

[rtl/pcvr_checker.sv]
// Port-level checks for the particle contact velocity resolve block, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pcvr_checker #(
  parameter int COMPONENT_WIDTH = 17
) (
  input logic                                       clk_i,
  input logic                                       rst_ni,
  input logic                                       s_axis_tready,
  input logic                                       m_axis_tvalid,
  input logic                                       m_axis_tready,
  input logic [((2*3*COMPONENT_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  input logic                                       m_axis_tuser
);

  // a stalled result holds its data
  `PCVR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // input side is throttled only by a result that waits
  `PCVR_ASSERT(a_in_ready, s_axis_tready == (m_axis_tready || !m_axis_tvalid), "input ready does not follow output stall")

  // reset empties the pipeline
  `PCVR_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !m_axis_tvalid, "result valid right after reset")

endmodule

bind particle_contact_velocity_resolve_unit pcvr_checker #(
  .COMPONENT_WIDTH (COMPONENT_WIDTH)
) u_pcvr_checker (.*);
